### src/bm_pkg.sv
package bm_pkg;

  // Capacity of the sample store and the widths that follow from it.
  localparam int MAX_ITEMS = 256;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  // Fixed field widths of the ports.
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 9;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_CMP,
    S_FIN,
    S_MA,
    S_MB,
    S_RES
  } state_t;

  // One finished result, handed from the sequencer to the output stage.
  typedef struct packed {
    logic [DATA_W-1:0]  median;
    logic [COUNT_W-1:0] count;
    logic               overflow;
  } res_t;

endpackage

### src/bm_ram.sv
module bm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/bm_core.sv
module bm_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bm_pkg::DATA_W-1:0]    sample,
  input  logic                         has_sample,
  input  logic                         last,
  output logic                         res_valid,
  output bm_pkg::res_t                 res,
  input  logic                         res_take
);

  bm_pkg::state_t state, state_next;

  logic [bm_pkg::CNT_W-1:0]  pos, pos_next;
  logic [bm_pkg::CNT_W-1:0]  count, count_next;
  logic                      drop, drop_next;
  logic [bm_pkg::DATA_W-1:0] value, value_next;
  logic                      last_q, last_next;
  logic [bm_pkg::DATA_W-1:0] lo, lo_next;
  logic [bm_pkg::DATA_W-1:0] res_med, res_med_next;

  logic                      we;
  logic [bm_pkg::ADDR_W-1:0] waddr;
  logic [bm_pkg::DATA_W-1:0] wdata;
  logic                      re;
  logic [bm_pkg::ADDR_W-1:0] raddr;
  logic [bm_pkg::DATA_W-1:0] rdata;

  logic                      accept;
  logic [bm_pkg::CNT_W-1:0]  pos_m1;
  logic [bm_pkg::CNT_W-1:0]  pos_m2;
  logic [bm_pkg::CNT_W-1:0]  mid_lo;
  logic [bm_pkg::DATA_W:0]   pair_sum;
  bm_pkg::state_t            done_state;

  // Sorted sample store.
  bm_ram #(
    .WIDTH (bm_pkg::DATA_W),
    .DEPTH (bm_pkg::MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall = (state != bm_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign pos_m1   = pos - bm_pkg::CNT_W'(1);
  assign pos_m2   = pos - bm_pkg::CNT_W'(2);
  assign mid_lo   = (count - bm_pkg::CNT_W'(1)) >> 1;
  assign pair_sum = {lo[bm_pkg::DATA_W-1], lo} + {rdata[bm_pkg::DATA_W-1], rdata};

  // After the sample is handled, either finish the block or wait for the next item.
  assign done_state = last_q ? bm_pkg::S_FIN : bm_pkg::S_IDLE;

  assign res_valid    = (state == bm_pkg::S_RES);
  assign res.median   = res_med;
  assign res.count    = bm_pkg::COUNT_W'(count);
  assign res.overflow = drop;

  // State and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bm_pkg::S_IDLE;
      count <= '0;
      drop  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      drop  <= drop_next;
    end
    pos     <= pos_next;
    value   <= value_next;
    last_q  <= last_next;
    lo      <= lo_next;
    res_med <= res_med_next;
  end

  // Sequencer: insertion by shifting larger entries up one place per cycle,
  // then the median read out of the middle of the store.
  always_comb begin
    state_next   = state;
    pos_next     = pos;
    count_next   = count;
    drop_next    = drop;
    value_next   = value;
    last_next    = last_q;
    lo_next      = lo;
    res_med_next = res_med;
    we           = 1'b0;
    waddr        = pos[bm_pkg::ADDR_W-1:0];
    wdata        = value;
    re           = 1'b0;
    raddr        = pos_m1[bm_pkg::ADDR_W-1:0];

    case (state)
      bm_pkg::S_IDLE: begin
        if (accept) begin
          value_next = sample;
          last_next  = last;
          pos_next   = count;
          if (has_sample) begin
            if (count >= bm_pkg::CNT_W'(bm_pkg::MAX_ITEMS)) begin
              drop_next  = 1'b1;
              state_next = last ? bm_pkg::S_FIN : bm_pkg::S_IDLE;
            end else begin
              state_next = bm_pkg::S_INS;
            end
          end else begin
            state_next = last ? bm_pkg::S_FIN : bm_pkg::S_IDLE;
          end
        end
      end

      bm_pkg::S_INS: begin
        if (pos == '0) begin
          we         = 1'b1;
          count_next = count + bm_pkg::CNT_W'(1);
          state_next = done_state;
        end else begin
          re         = 1'b1;
          state_next = bm_pkg::S_CMP;
        end
      end

      bm_pkg::S_CMP: begin
        // The entry just below the gap is in rdata.
        if ($signed(rdata) > $signed(value)) begin
          we       = 1'b1;
          wdata    = rdata;
          pos_next = pos_m1;
          if (pos == bm_pkg::CNT_W'(1)) begin
            state_next = bm_pkg::S_INS;
          end else begin
            re    = 1'b1;
            raddr = pos_m2[bm_pkg::ADDR_W-1:0];
          end
        end else begin
          we         = 1'b1;
          count_next = count + bm_pkg::CNT_W'(1);
          state_next = done_state;
        end
      end

      bm_pkg::S_FIN: begin
        if (count == '0) begin
          res_med_next = '0;
          state_next   = bm_pkg::S_RES;
        end else begin
          re         = 1'b1;
          raddr      = mid_lo[bm_pkg::ADDR_W-1:0];
          state_next = bm_pkg::S_MA;
        end
      end

      bm_pkg::S_MA: begin
        lo_next = rdata;
        if (count[0]) begin
          res_med_next = rdata;
          state_next   = bm_pkg::S_RES;
        end else begin
          re         = 1'b1;
          raddr      = mid_lo[bm_pkg::ADDR_W-1:0] + bm_pkg::ADDR_W'(1);
          state_next = bm_pkg::S_MB;
        end
      end

      bm_pkg::S_MB: begin
        // Mean of the two middle entries, floored by the arithmetic shift.
        res_med_next = pair_sum[bm_pkg::DATA_W:1];
        state_next   = bm_pkg::S_RES;
      end

      bm_pkg::S_RES: begin
        if (res_take) begin
          count_next = '0;
          drop_next  = 1'b0;
          state_next = bm_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = bm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### src/block_median.sv
// An insertion moves each stored sample larger than the new one up one place, then writes it;
// finishing reads the middle entry, or both middle entries if even, into the output register.
// Throughput: one input transaction at a time, the next accepted only once the last is handled,
// set by the single read-compare-write loop over the store's one write and read port.
// Reset clears the sequencer, the sample count and the overflow flag; the store is not cleared.
module block_median (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bm_pkg::DATA_W-1:0]    sample,
  input  logic                         has_sample,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bm_pkg::DATA_W-1:0]    median,
  output logic [bm_pkg::COUNT_W-1:0]   count,
  output logic                         overflow
);

  logic         res_valid;
  logic         res_take;
  bm_pkg::res_t res;

  bm_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .has_sample (has_sample),
    .last       (last),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take)
  );

  // The output register takes a result whenever it is empty or being emptied.
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_take) begin
      median   <= res.median;
      count    <= res.count;
      overflow <= res.overflow;
    end
  end

endmodule
